@@ rtl/mit_pkg.sv @@
// types, constants and cofactor index tables for the 3x3 inverse-transpose unit
// no dependencies
package mit_pkg;

  localparam int EW  = 24;               // entry width, Q8.16
  localparam int PW  = 48;               // entry product width
  localparam int KW  = 49;               // cofactor width, Q17.32
  localparam int DW  = 73;               // determinant width, Q25.48 signed
  localparam int MW  = 72;               // determinant magnitude width
  localparam int NW  = 81;               // dividend width
  localparam int QW  = 25;               // quotient bits resolved
  localparam int CW  = MW + 1 + QW;      // compare width in the divider
  localparam int KLW = 25;               // low part of a cofactor in the det products
  localparam int TW  = 32;               // threshold register width

  localparam logic [TW-1:0] THRESH_RESET = 32'd281474977;
  localparam logic [EW-1:0] ONE_Q16      = 24'd65536;
  localparam logic [QW-1:0] POS_LIM      = 25'd8388607;
  localparam logic [QW-1:0] NEG_LIM      = 25'd8388608;
  localparam logic [EW-1:0] POS_SAT      = 24'h7fffff;
  localparam logic [EW-1:0] NEG_SAT      = 24'h800000;

  localparam logic REG_THRESH = 1'b0;

  // cofactor k = a[CF_A]*a[CF_B] - a[CF_C]*a[CF_D], entries row by row
  localparam int CF_A [9] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
  localparam int CF_B [9] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
  localparam int CF_C [9] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
  localparam int CF_D [9] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

  typedef struct packed {
    logic signed [EW-1:0] in_r0c0;
    logic signed [EW-1:0] in_r0c1;
    logic signed [EW-1:0] in_r0c2;
    logic signed [EW-1:0] in_r1c0;
    logic signed [EW-1:0] in_r1c1;
    logic signed [EW-1:0] in_r1c2;
    logic signed [EW-1:0] in_r2c0;
    logic signed [EW-1:0] in_r2c1;
    logic signed [EW-1:0] in_r2c2;
  } in_item_t;

  typedef struct packed {
    logic signed [EW-1:0] out_r0c0;
    logic signed [EW-1:0] out_r0c1;
    logic signed [EW-1:0] out_r0c2;
    logic signed [EW-1:0] out_r1c0;
    logic signed [EW-1:0] out_r1c1;
    logic signed [EW-1:0] out_r1c2;
    logic signed [EW-1:0] out_r2c0;
    logic signed [EW-1:0] out_r2c1;
    logic signed [EW-1:0] out_r2c2;
    logic                 singular;
    logic                 saturated;
  } out_item_t;

  typedef struct packed {
    logic                    valid;
    logic [2:0][EW-1:0]      row0;
    logic [8:0][KW-1:0]      k;
  } cof_t;

  typedef struct packed {
    logic                    valid;
    logic                    singular;
    logic [MW-1:0]           dmag;
    logic [8:0]              neg;
    logic [8:0][NW-1:0]      num;
  } div_in_t;

endpackage

@@ rtl/matrix_inverse_transpose_3x3_unit.sv @@
// top level of the 3x3 inverse-transpose unit: register port and pipeline
// depends on mit_pkg, mit_cofactor, mit_det, mit_divide
// One matrix item is taken in every cycle; each result passes through the three cofactor
// and determinant stages each, one stage per quotient bit in the 25-bit divider, and its
// entry and output registers. busy is high only in reset, the result strobe done lasts one
// cycle and cannot be held off by the receiver.
module matrix_inverse_transpose_3x3_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  mit_pkg::in_item_t        in_item,
  output logic                     done,
  output mit_pkg::out_item_t       result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int LAT = 33;

  logic [mit_pkg::TW-1:0] thresh;
  mit_pkg::cof_t          cof;
  mit_pkg::div_in_t       dvin;
  logic                   accept;

  assign busy   = rst;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mit_pkg::REG_THRESH) ? thresh : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= mit_pkg::THRESH_RESET;
    end else if (psel && penable && pwrite && paddr[2] == mit_pkg::REG_THRESH) begin
      thresh <= pwdata;
    end
  end

  mit_cofactor u_cof (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_item (in_item),
    .cof     (cof)
  );

  mit_det u_det (
    .clk    (clk),
    .rst    (rst),
    .thresh (thresh),
    .cof    (cof),
    .dvin   (dvin)
  );

  mit_divide u_div (
    .clk    (clk),
    .rst    (rst),
    .dvin   (dvin),
    .done   (done),
    .result (result)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without a matching item");

  a_sing_nosat: assert property (@(posedge clk) disable iff (rst)
    done && result.singular |-> !result.saturated)
    else $error("saturation flagged on identity result");

  a_sing_ident: assert property (@(posedge clk) disable iff (rst)
    done && result.singular |-> result.out_r0c0 == mit_pkg::ONE_Q16 &&
      result.out_r1c1 == mit_pkg::ONE_Q16 && result.out_r0c1 == '0)
    else $error("singular result is not the identity");

endmodule

@@ rtl/mit_cofactor.sv @@
// input register, entry products and cofactor subtraction (three stages)
// depends on mit_pkg
module mit_cofactor (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  mit_pkg::in_item_t in_item,
  output mit_pkg::cof_t     cof
);

  logic [8:0][mit_pkg::EW-1:0] a;
  logic                        v1;
  logic [8:0][mit_pkg::PW-1:0] p1;
  logic [8:0][mit_pkg::PW-1:0] p2;
  logic [2:0][mit_pkg::EW-1:0] row2;
  logic                        v2;
  logic [8:0][mit_pkg::PW-1:0] p1_next;
  logic [8:0][mit_pkg::PW-1:0] p2_next;
  logic [8:0][mit_pkg::KW-1:0] k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    a[0] <= in_item.in_r0c0;
    a[1] <= in_item.in_r0c1;
    a[2] <= in_item.in_r0c2;
    a[3] <= in_item.in_r1c0;
    a[4] <= in_item.in_r1c1;
    a[5] <= in_item.in_r1c2;
    a[6] <= in_item.in_r2c0;
    a[7] <= in_item.in_r2c1;
    a[8] <= in_item.in_r2c2;
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p1_next[i] = mit_pkg::PW'($signed(a[mit_pkg::CF_A[i]]) * $signed(a[mit_pkg::CF_B[i]]));
      p2_next[i] = mit_pkg::PW'($signed(a[mit_pkg::CF_C[i]]) * $signed(a[mit_pkg::CF_D[i]]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    p1   <= p1_next;
    p2   <= p2_next;
    row2 <= a[2:0];
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      k_next[i] = mit_pkg::KW'($signed(p1[i])) - mit_pkg::KW'($signed(p2[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cof.valid <= 1'b0;
    end else begin
      cof.valid <= v2;
    end
    cof.k    <= k_next;
    cof.row0 <= row2;
  end

endmodule

@@ rtl/mit_det.sv @@
// determinant by row 0 expansion, magnitude, singular test, dividend set-up
// depends on mit_pkg
module mit_det (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [mit_pkg::TW-1:0]   thresh,
  input  mit_pkg::cof_t            cof,
  output mit_pkg::div_in_t         dvin
);

  localparam int PLW = mit_pkg::EW + mit_pkg::KLW + 1;
  localparam int PHW = mit_pkg::EW + mit_pkg::KW - mit_pkg::KLW;

  logic                             v4;
  logic [2:0][PLW-1:0]              plo;
  logic [2:0][PHW-1:0]              phi;
  logic [8:0][mit_pkg::KW-1:0]      k4;
  logic                             v5;
  logic signed [mit_pkg::DW-1:0]    det;
  logic [8:0][mit_pkg::KW-1:0]      k5;
  logic signed [mit_pkg::DW-1:0]    det_next;
  logic [mit_pkg::MW-1:0]           dmag;
  logic                             dneg;
  logic [8:0][mit_pkg::NW-1:0]      num_next;
  logic [8:0]                       neg_next;
  logic [mit_pkg::KW-2:0]           km;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= cof.valid;
    end
    for (int j = 0; j < 3; j++) begin
      plo[j] <= PLW'($signed(cof.row0[j]) *
                     $signed({1'b0, cof.k[j][mit_pkg::KLW-1:0]}));
      phi[j] <= PHW'($signed(cof.row0[j]) *
                     $signed(cof.k[j][mit_pkg::KW-1:mit_pkg::KLW]));
    end
    k4 <= cof.k;
  end

  always_comb begin
    det_next = '0;
    for (int j = 0; j < 3; j++) begin
      det_next = det_next + (mit_pkg::DW'($signed(phi[j])) <<< mit_pkg::KLW)
                          + mit_pkg::DW'($signed(plo[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    det <= det_next;
    k5  <= k4;
  end

  always_comb begin
    dneg = det[mit_pkg::DW-1];
    dmag = dneg ? mit_pkg::MW'(-det) : mit_pkg::MW'(det);
    km   = '0;
    for (int i = 0; i < 9; i++) begin
      km = k5[i][mit_pkg::KW-1] ? (mit_pkg::KW-1)'(-$signed(k5[i]))
                                : k5[i][mit_pkg::KW-2:0];
      num_next[i] = mit_pkg::NW'({km, 33'b0}) + mit_pkg::NW'(dmag);
      neg_next[i] = k5[i][mit_pkg::KW-1] ^ dneg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvin.valid <= 1'b0;
    end else begin
      dvin.valid <= v5;
    end
    dvin.singular <= (dmag < mit_pkg::MW'(thresh)) || (dmag == '0);
    dvin.dmag     <= dmag;
    dvin.neg      <= neg_next;
    dvin.num      <= num_next;
  end

endmodule

@@ rtl/mit_divide.sv @@
// nine-lane rounded divider, one quotient bit per stage, then clamp and output register
// depends on mit_pkg
module mit_divide (
  input  logic               clk,
  input  logic               rst,
  input  mit_pkg::div_in_t   dvin,
  output logic               done,
  output mit_pkg::out_item_t result
);

  localparam int QW = mit_pkg::QW;
  localparam int CW = mit_pkg::CW;
  localparam int NW = mit_pkg::NW;

  logic                          vld  [0:QW];
  logic                          sing [0:QW];
  logic [mit_pkg::MW:0]          den2 [0:QW];
  logic [8:0]                    neg  [0:QW];
  logic [8:0]                    ovf  [0:QW];
  logic [8:0][NW-1:0]            rem  [0:QW];
  logic [8:0][QW-1:0]            quo  [0:QW];

  logic [mit_pkg::MW:0]          d2_in;
  logic [CW-1:0]                 top_cmp;
  logic [8:0]                    ovf_next;

  always_comb begin
    d2_in   = {dvin.dmag, 1'b0};
    top_cmp = CW'(d2_in) << QW;
    for (int l = 0; l < 9; l++) begin
      ovf_next[l] = CW'(dvin.num[l]) >= top_cmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= dvin.valid;
    end
    sing[0] <= dvin.singular;
    den2[0] <= d2_in;
    neg[0]  <= dvin.neg;
    ovf[0]  <= ovf_next;
    rem[0]  <= dvin.num;
    quo[0]  <= '0;
  end

  for (genvar g = 0; g < QW; g++) begin : g_bit
    localparam int SH = QW - 1 - g;
    logic [CW-1:0]     cmp;
    logic [8:0]        hit;
    logic [8:0][NW-1:0] rem_next;

    always_comb begin
      cmp = CW'(den2[g]) << SH;
      for (int l = 0; l < 9; l++) begin
        hit[l]      = CW'(rem[g][l]) >= cmp;
        rem_next[l] = hit[l] ? NW'(CW'(rem[g][l]) - cmp) : rem[g][l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
      sing[g+1] <= sing[g];
      den2[g+1] <= den2[g];
      neg[g+1]  <= neg[g];
      ovf[g+1]  <= ovf[g];
      rem[g+1]  <= rem_next;
      for (int l = 0; l < 9; l++) begin
        quo[g+1][l] <= {quo[g][l][QW-2:0], hit[l]};
      end
    end
  end

  logic [8:0][mit_pkg::EW-1:0] res;
  logic [8:0]                  lsat;
  logic [QW-1:0]               q;

  always_comb begin
    q = '0;
    for (int l = 0; l < 9; l++) begin
      q       = quo[QW][l];
      lsat[l] = 1'b0;
      if (sing[QW]) begin
        res[l] = (l == 0 || l == 4 || l == 8) ? mit_pkg::ONE_Q16 : '0;
      end else if (!ovf[QW][l] && q == '0) begin
        res[l] = '0;
      end else if (neg[QW][l]) begin
        if (ovf[QW][l] || q > mit_pkg::NEG_LIM) begin
          res[l]  = mit_pkg::NEG_SAT;
          lsat[l] = 1'b1;
        end else begin
          res[l] = mit_pkg::EW'(QW'(0) - q);
        end
      end else begin
        if (ovf[QW][l] || q > mit_pkg::POS_LIM) begin
          res[l]  = mit_pkg::POS_SAT;
          lsat[l] = 1'b1;
        end else begin
          res[l] = mit_pkg::EW'(q);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[QW];
    end
    result.out_r0c0  <= res[0];
    result.out_r0c1  <= res[1];
    result.out_r0c2  <= res[2];
    result.out_r1c0  <= res[3];
    result.out_r1c1  <= res[4];
    result.out_r1c2  <= res[5];
    result.out_r2c0  <= res[6];
    result.out_r2c1  <= res[7];
    result.out_r2c2  <= res[8];
    result.singular  <= sing[QW];
    result.saturated <= |lsat;
  end

endmodule
